// ===== rtl/planar_arm_forward_kinematics_assert.svh =====
// Assertion macros used by the planar arm forward kinematics RTL.
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_ASSERT_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_ASSERT_SVH

// same-cycle implication, held off during reset
`define PAFK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pafk assertion failed");

// next-cycle implication, held off during reset
`define PAFK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pafk assertion failed");

`endif

// ===== rtl/pafk_pkg.sv =====
// Types, constants and helpers of the planar arm forward kinematics block.
package pafk_pkg;

	localparam int PW        = 24;   // position width, Q16 signed
	localparam int HW        = 16;   // binary angle width
	localparam int LW        = 20;   // link length width, Q16 unsigned
	localparam int CW        = 32;   // CORDIC datapath width, 30 fraction bits
	localparam int PRW       = LW + 1 + CW;   // length times trig product
	localparam int FRAC      = 30;   // fraction bits of trig values
	localparam int VW        = PRW - FRAC;    // rounded link vector
	localparam int SW        = PW + 2;        // chained position sum
	localparam int NLANE     = 3;
	localparam int TABLE_LEN = 24;
	localparam int IDXW      = 2;
	localparam int IN_W      = 2 * PW + 3 * HW;
	localparam int OUT_W     = 6 * PW + 3 * HW;

	typedef enum logic [IDXW-1:0] {
		REG_FIRST_LEN  = 2'd0,
		REG_SECOND_LEN = 2'd1,
		REG_THIRD_LEN  = 2'd2
	} reg_idx_t;

	localparam logic [LW-1:0] FIRST_LEN_RST  = 20'd52429;
	localparam logic [LW-1:0] SECOND_LEN_RST = 20'd39322;
	localparam logic [LW-1:0] THIRD_LEN_RST  = 20'd19661;

	// inverse CORDIC gain, 30 fraction bits
	localparam logic [CW-1:0] INV_GAIN = 32'd652032874;
	// half an output lsb, for round half up
	localparam logic [PRW-1:0] ROUND_HALF = 53'h0000020000000;

	localparam logic [PW-1:0] POS_MAX = 24'h7FFFFF;
	localparam logic [PW-1:0] POS_MIN = 24'h800000;

	// atan(2^-i) as a 32-bit binary angle
	localparam logic [CW-1:0] STEP_ANGLE [0:TABLE_LEN-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// one CORDIC lane
	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} rot_t;

	// per-item data riding alongside the CORDIC lanes
	typedef struct packed {
		logic [PW-1:0]    bx;
		logic [PW-1:0]    by;
		logic [HW-1:0]    h1;
		logic [HW-1:0]    h2;
		logic [HW-1:0]    h3;
		logic [NLANE-1:0] flip;
	} meta_t;

	// clamp a chained sum into the position range
	function automatic logic [PW-1:0] sat_pos(input logic [SW-1:0] v);
		logic ovf;
		begin
			ovf = (v[SW-1:PW-1] != {(SW-PW+1){1'b0}}) && (v[SW-1:PW-1] != {(SW-PW+1){1'b1}});
			if (!ovf)
				sat_pos = v[PW-1:0];
			else if (v[SW-1])
				sat_pos = POS_MIN;
			else
				sat_pos = POS_MAX;
		end
	endfunction

endpackage

// ===== rtl/planar_arm_forward_kinematics.sv =====
// Pipelined forward kinematics of a mobile base with a three-link planar arm.
//
//  channel | direction | handshake            | contents
//  s_*     | in        | s_tvalid / s_tready  | base position, three joint angles
//  m_*     | out       | m_tvalid / m_tready  | elbow, wrist, tip positions, headings
//  cfg_*   | in        | cfg_valid / cfg_ready| link length writes by index
//
// One item per cycle sustained unless the output stalls; TRIG_ITERATIONS + 5
// register stages (one CORDIC rotation step per stage plus input, multiply, round,
// chain and saturate). Every stage has its own valid bit and loads when the output
// is taken or when it or any later stage is empty, so bubbles are squeezed out while
// the output is stalled. Reset clears the valid bits and restores the lengths.
module planar_arm_forward_kinematics
	import pafk_pkg::*;
#(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// base_x[23:0], base_y[47:24], shoulder_angle[63:48], elbow_angle[79:64],
	// wrist_angle[95:80]
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// elbow_x[23:0], elbow_y[47:24], wrist_x[71:48], wrist_y[95:72],
	// tip_x[119:96], tip_y[143:120], first_heading[159:144],
	// second_heading[175:160], third_heading[191:176]
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDXW-1:0]  cfg_index,
	input  logic [LW-1:0]    cfg_data
);

	localparam int NIT    = TRIG_ITERATIONS;
	localparam int ST_MUL = NIT + 1;
	localparam int ST_RND = NIT + 2;
	localparam int NS     = NIT + 5;

	// link length registers
	logic [LW-1:0] len_q [0:NLANE-1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0] <= FIRST_LEN_RST;
			len_q[1] <= SECOND_LEN_RST;
			len_q[2] <= THIRD_LEN_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_FIRST_LEN:  len_q[0] <= cfg_data;
				REG_SECOND_LEN: len_q[1] <= cfg_data;
				REG_THIRD_LEN:  len_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables: load when the output is ready or this stage or any later one has room
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_comb begin : en_calc
		logic [NS-1:0] low_mask;
		for (int k = 0; k < NS; k++) begin
			low_mask = ({{(NS-1){1'b0}}, 1'b1} << k) - {{(NS-1){1'b0}}, 1'b1};
			en[k] = m_tready || !(&(vld_q | low_mask));
		end
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= (vld_q & ~en) | ({vld_q[NS-2:0], s_tvalid} & en);
	end

	// payload registers
	meta_t               meta_s [0:ST_RND];
	rot_t                rot_s  [0:NIT][0:NLANE-1];
	logic signed [PRW-1:0] prod_s [0:2*NLANE-1];
	logic [VW-1:0]       vec_s  [0:2*NLANE-1];
	logic [SW-1:0]       pos_s  [0:2*NLANE-1];
	logic [HW-1:0]       hd_s   [0:NLANE-1];
	logic [PW-1:0]       res_s  [0:2*NLANE-1];
	logic [HW-1:0]       hdo_s  [0:NLANE-1];

	// input stage: cumulative headings, fold into the half turn around zero
	meta_t        meta_in;
	rot_t         rot_in [0:NLANE-1];
	logic [HW-1:0] hd_in [0:NLANE-1];

	always_comb begin
		meta_in.bx = s_tdata[PW-1:0];
		meta_in.by = s_tdata[2*PW-1:PW];
		meta_in.h1 = s_tdata[2*PW+HW-1:2*PW];
		meta_in.h2 = meta_in.h1 + s_tdata[2*PW+2*HW-1:2*PW+HW];
		meta_in.h3 = meta_in.h2 + s_tdata[2*PW+3*HW-1:2*PW+2*HW];
		hd_in[0] = meta_in.h1;
		hd_in[1] = meta_in.h2;
		hd_in[2] = meta_in.h3;
		for (int l = 0; l < NLANE; l++) begin
			meta_in.flip[l] = hd_in[l][HW-1] ^ hd_in[l][HW-2];
			rot_in[l].x = INV_GAIN;
			rot_in[l].y = '0;
			rot_in[l].z = {hd_in[l][HW-1] ^ meta_in.flip[l], hd_in[l][HW-2:0],
				{(CW-HW){1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			meta_s[0] <= meta_in;
			for (int l = 0; l < NLANE; l++)
				rot_s[0][l] <= rot_in[l];
		end
	end

	// CORDIC rotation stages, one step each
	for (genvar i = 0; i < NIT; i++) begin : g_cordic
		rot_t rot_nxt [0:NLANE-1];

		always_comb begin
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			for (int l = 0; l < NLANE; l++) begin
				// arithmetic shifts of the signed lane values
				dx = $signed(rot_s[i][l].y) >>> i;
				dy = $signed(rot_s[i][l].x) >>> i;
				if (!rot_s[i][l].z[CW-1]) begin
					rot_nxt[l].x = rot_s[i][l].x - dx;
					rot_nxt[l].y = rot_s[i][l].y + dy;
					rot_nxt[l].z = rot_s[i][l].z - STEP_ANGLE[i];
				end else begin
					rot_nxt[l].x = rot_s[i][l].x + dx;
					rot_nxt[l].y = rot_s[i][l].y - dy;
					rot_nxt[l].z = rot_s[i][l].z + STEP_ANGLE[i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				meta_s[i+1] <= meta_s[i];
				for (int l = 0; l < NLANE; l++)
					rot_s[i+1][l] <= rot_nxt[l];
			end
		end
	end

	// multiply stage: undo the half-turn fold, scale by link length
	logic [CW-1:0] cos_m [0:NLANE-1];
	logic [CW-1:0] sin_m [0:NLANE-1];

	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			cos_m[l] = meta_s[NIT].flip[l] ? -rot_s[NIT][l].x : rot_s[NIT][l].x;
			sin_m[l] = meta_s[NIT].flip[l] ? -rot_s[NIT][l].y : rot_s[NIT][l].y;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			meta_s[ST_MUL] <= meta_s[NIT];
			for (int l = 0; l < NLANE; l++) begin
				prod_s[2*l]   <= $signed({1'b0, len_q[l]}) * $signed(cos_m[l]);
				prod_s[2*l+1] <= $signed({1'b0, len_q[l]}) * $signed(sin_m[l]);
			end
		end
	end

	// round stage: half up to 16 fraction bits
	logic [PRW-1:0] rnd_sum [0:2*NLANE-1];

	always_comb begin
		for (int j = 0; j < 2 * NLANE; j++)
			rnd_sum[j] = prod_s[j] + ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		if (en[ST_RND]) begin
			meta_s[ST_RND] <= meta_s[ST_MUL];
			for (int j = 0; j < 2 * NLANE; j++)
				vec_s[j] <= rnd_sum[j][PRW-1:FRAC];
		end
	end

	// chain stage: add link vectors onto the base at full precision
	logic [SW-1:0] bx_e, by_e;
	logic [SW-1:0] vec_e [0:2*NLANE-1];

	always_comb begin
		bx_e = {{(SW-PW){meta_s[ST_RND].bx[PW-1]}}, meta_s[ST_RND].bx};
		by_e = {{(SW-PW){meta_s[ST_RND].by[PW-1]}}, meta_s[ST_RND].by};
		for (int j = 0; j < 2 * NLANE; j++)
			vec_e[j] = {{(SW-VW){vec_s[j][VW-1]}}, vec_s[j]};
	end

	always_ff @(posedge clk) begin
		if (en[NIT+3]) begin
			pos_s[0] <= bx_e + vec_e[0];
			pos_s[1] <= by_e + vec_e[1];
			pos_s[2] <= bx_e + vec_e[0] + vec_e[2];
			pos_s[3] <= by_e + vec_e[1] + vec_e[3];
			pos_s[4] <= bx_e + vec_e[0] + vec_e[2] + vec_e[4];
			pos_s[5] <= by_e + vec_e[1] + vec_e[3] + vec_e[5];
			hd_s[0]  <= meta_s[ST_RND].h1;
			hd_s[1]  <= meta_s[ST_RND].h2;
			hd_s[2]  <= meta_s[ST_RND].h3;
		end
	end

	// output stage: saturate each position alone
	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			for (int j = 0; j < 2 * NLANE; j++)
				res_s[j] <= sat_pos(pos_s[j]);
			for (int l = 0; l < NLANE; l++)
				hdo_s[l] <= hd_s[l];
		end
	end

	assign m_tvalid = vld_q[NS-1];
	assign m_tdata  = {hdo_s[2], hdo_s[1], hdo_s[0],
		res_s[5], res_s[4], res_s[3], res_s[2], res_s[1], res_s[0]};

`include "planar_arm_forward_kinematics_assert.svh"

	// a full pipeline with a stalled output takes nothing in
	`PAFK_ASSERT_NOW(a_full_blocks_input, clk, arst_n, (&vld_q) && !m_tready, !s_tready)
	// folded start angles lie in the half turn around zero
	`PAFK_ASSERT_NOW(a_fold_in_range, clk, arst_n, vld_q[0],
		(rot_s[0][0].z[CW-1] == rot_s[0][0].z[CW-2]) &&
		(rot_s[0][1].z[CW-1] == rot_s[0][1].z[CW-2]) &&
		(rot_s[0][2].z[CW-1] == rot_s[0][2].z[CW-2]))
	// a result appears only from an item held in the stage before
	`PAFK_ASSERT_NEXT(a_out_from_pipe, clk, arst_n, !m_tvalid, !m_tvalid || $past(vld_q[NS-2]))

endmodule

// ===== dv/tb_planar_arm_forward_kinematics.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the planar arm forward kinematics pipeline.
module tb_planar_arm_forward_kinematics;
	import pafk_pkg::*;

	localparam int TRIG_ITERATIONS = 16;
	localparam int LATENCY         = TRIG_ITERATIONS + 5;
	localparam int ATAN_ENTRIES    = 24;

	// CORDIC start value (inverse gain) and rounding offset, 30 fraction bits
	localparam longint CORDIC_X0   = 64'sd652032874;
	localparam longint HALF_LSB    = 64'sd536870912;
	localparam longint POSITION_HI = 64'sd8388607;
	localparam longint POSITION_LO = -64'sd8388608;
	localparam logic [LW-1:0] LEN_MAX = 20'hFFFFF;
	// index outside the register list, writes to it must be dropped
	localparam logic [IDXW-1:0] UNUSED_REG_IDX = 2'd3;

	localparam longint ATAN_STEP [ATAN_ENTRIES] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// one input item, first field in the low bits
	typedef struct packed {
		logic [15:0] wrist;
		logic [15:0] elbow;
		logic [15:0] shoulder;
		logic [23:0] base_y;
		logic [23:0] base_x;
	} posture_t;

	// one result item, first field in the low bits
	typedef struct packed {
		logic [15:0] third_heading;
		logic [15:0] second_heading;
		logic [15:0] first_heading;
		logic [23:0] tip_y;
		logic [23:0] tip_x;
		logic [23:0] wrist_y;
		logic [23:0] wrist_x;
		logic [23:0] elbow_y;
		logic [23:0] elbow_x;
	} arm_pose_t;

	// expected poses in arrival order, with the predictor and its own link lengths
	class pose_checker;
		logic [LW-1:0] link_len [3];
		arm_pose_t pending_poses [$];
		int mismatches;

		function new();
			link_len[0] = 20'd52429;
			link_len[1] = 20'd39322;
			link_len[2] = 20'd19661;
			mismatches = 0;
		endfunction

		function void set_length(input logic [IDXW-1:0] idx, input logic [LW-1:0] value);
			case (idx)
				REG_FIRST_LEN:  link_len[0] = value;
				REG_SECOND_LEN: link_len[1] = value;
				REG_THIRD_LEN:  link_len[2] = value;
				default: ;
			endcase
		endfunction

		// cosine and sine of a binary angle, 30 fraction bits
		function void rotate(input logic [15:0] heading, output longint cos_v,
				output longint sin_v);
			logic [31:0] ang;
			longint x, y, z, dx, dy;
			bit turn;
			ang = {heading, 16'h0000};
			// rotate the left half plane by a half turn and negate afterwards
			turn = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
			if (turn)
				ang = ang + 32'h8000_0000;
			z = $signed(ang);
			x = CORDIC_X0;
			y = 0;
			for (int i = 0; i < TRIG_ITERATIONS && i < ATAN_ENTRIES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_STEP[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_STEP[i];
				end
			end
			cos_v = turn ? -x : x;
			sin_v = turn ? -y : y;
		endfunction

		// length times trig, rounded half up to 16 fraction bits
		function longint scale(input logic [LW-1:0] len, input longint trig_v);
			longint l;
			l = longint'({44'd0, len});
			return (l * trig_v + HALF_LSB) >>> 30;
		endfunction

		function logic [23:0] clamp(input longint v);
			if (v > POSITION_HI)
				return 24'h7FFFFF;
			if (v < POSITION_LO)
				return 24'h800000;
			return v[23:0];
		endfunction

		function arm_pose_t compute_pose(input posture_t p);
			arm_pose_t r;
			logic [15:0] h1, h2, h3;
			longint ex, ey, wx, wy, tx, ty, c, s;
			h1 = p.shoulder;
			h2 = h1 + p.elbow;
			h3 = h2 + p.wrist;
			// chain at full precision, clamp each position on its own
			rotate(h1, c, s);
			ex = longint'($signed(p.base_x)) + scale(link_len[0], c);
			ey = longint'($signed(p.base_y)) + scale(link_len[0], s);
			rotate(h2, c, s);
			wx = ex + scale(link_len[1], c);
			wy = ey + scale(link_len[1], s);
			rotate(h3, c, s);
			tx = wx + scale(link_len[2], c);
			ty = wy + scale(link_len[2], s);
			r.elbow_x = clamp(ex);
			r.elbow_y = clamp(ey);
			r.wrist_x = clamp(wx);
			r.wrist_y = clamp(wy);
			r.tip_x = clamp(tx);
			r.tip_y = clamp(ty);
			r.first_heading = h1;
			r.second_heading = h2;
			r.third_heading = h3;
			return r;
		endfunction

		function void note_posture(input posture_t p);
			pending_poses.insert(pending_poses.size(), compute_pose(p));
		endfunction

		function int pending();
			return pending_poses.size();
		endfunction

		function void compare_field(input string name, input logic [23:0] want,
				input logic [23:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH %s: expected %h, got %h at %0t", name, want, got,
						$realtime);
			end
		endfunction

		function void check_pose(input arm_pose_t got);
			arm_pose_t want;
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH unexpected item %h at %0t", got, $realtime);
				return;
			end
			want = pending_poses.pop_front();
			compare_field("elbow_x", want.elbow_x, got.elbow_x);
			compare_field("elbow_y", want.elbow_y, got.elbow_y);
			compare_field("wrist_x", want.wrist_x, got.wrist_x);
			compare_field("wrist_y", want.wrist_y, got.wrist_y);
			compare_field("tip_x", want.tip_x, got.tip_x);
			compare_field("tip_y", want.tip_y, got.tip_y);
			compare_field("first_heading", want.first_heading, got.first_heading);
			compare_field("second_heading", want.second_heading, got.second_heading);
			compare_field("third_heading", want.third_heading, got.third_heading);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDXW-1:0]  cfg_index;
	logic [LW-1:0]    cfg_data;

	pose_checker sb;
	bit src_burst;
	bit sink_burst;
	int sink_hold;

	planar_arm_forward_kinematics #(
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// result side: random stalls, one long hold when asked
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold) @(negedge clk);
				sink_hold = 0;
			end
			stall = sink_burst ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			sb.check_pose(m_tdata);
		end
	end

	task automatic send_posture(input posture_t p);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sb.note_posture(p);
	endtask

	task automatic write_length(input logic [IDXW-1:0] idx, input logic [LW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.set_length(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, wait for every expected item and let the pipe settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic posture_t make_posture(input logic [23:0] bx, input logic [23:0] by,
			input logic [15:0] sh, input logic [15:0] el, input logic [15:0] wr);
		posture_t p;
		p.base_x = bx;
		p.base_y = by;
		p.shoulder = sh;
		p.elbow = el;
		p.wrist = wr;
		return p;
	endfunction

	function automatic logic [15:0] random_angle();
		logic [15:0] a;
		a = 16'($urandom);
		// now and then sit on or right next to a quadrant boundary
		if ($urandom_range(0, 5) == 0)
			a = {a[15:14], 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
		return a;
	endfunction

	function automatic logic [23:0] random_coord();
		logic [23:0] v;
		v = 24'($urandom);
		if ($urandom_range(0, 3) == 0)
			v = {{6{v[17]}}, v[17:0]};
		return v;
	endfunction

	// random postures; idling modes redrawn in stretches
	task automatic run_random(input int count, input bit src_busy);
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				src_burst = src_busy || ($urandom_range(0, 3) == 0);
				sink_burst = ($urandom_range(0, 3) == 0);
			end
			send_posture(make_posture(random_coord(), random_coord(), random_angle(),
				random_angle(), random_angle()));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_burst = 1'b0;
		sink_burst = 1'b0;
		sink_hold = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset lengths
		run_random(90, 1'b0);
		drain();

		// longest links; a write past the register list must change nothing
		write_length(REG_FIRST_LEN, LEN_MAX);
		write_length(REG_SECOND_LEN, LEN_MAX);
		write_length(UNUSED_REG_IDX, 20'($urandom));
		write_length(REG_THIRD_LEN, LEN_MAX);
		src_burst = 1'b0;
		sink_burst = 1'b0;
		send_posture(make_posture(24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000));
		send_posture(make_posture(24'h7FFFFF, 24'h7FFFFF, 16'h0000, 16'h0000, 16'h0000));
		send_posture(make_posture(24'h800000, 24'h800000, 16'h8000, 16'h0000, 16'h0000));
		// elbow clamps, yet the wrist folds back into range
		send_posture(make_posture(24'h7FFFFF, 24'h000000, 16'h0000, 16'h8000, 16'h0000));
		send_posture(make_posture(24'h000000, 24'h800000, 16'hC000, 16'h8000, 16'h8000));
		send_posture(make_posture(24'h7FFFFF, 24'h800000, 16'h4000, 16'h4000, 16'h4000));
		send_posture(make_posture(24'h000001, 24'hFFFFFF, 16'h3FFF, 16'h0001, 16'h0001));
		send_posture(make_posture(24'hFFFFFF, 24'h000001, 16'hBFFF, 16'h0002, 16'hFFFE));
		// headings wrap past a full turn
		send_posture(make_posture(24'h123456, 24'hEDCBA9, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_posture(make_posture(24'h000000, 24'h000000, 16'hC000, 16'h4000, 16'h8000));
		send_posture(make_posture(24'h400000, 24'hC00000, 16'h4001, 16'h7FFF, 16'h8000));
		send_posture(make_posture(24'h555555, 24'hAAAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		send_posture(make_posture(24'hAAAAAA, 24'h555555, 16'hAAAA, 16'h5555, 16'hAAAA));
		send_posture(make_posture(24'h000001, 24'hFFFFFF, 16'h8000, 16'h0000, 16'h8000));
		send_posture(make_posture(24'h7F0000, 24'h810000, 16'h2000, 16'h2000, 16'h2000));
		send_posture(make_posture(24'h7FFFFF, 24'h800000, 16'hE000, 16'h6000, 16'hC000));
		run_random(80, 1'b0);
		drain();

		// zero-length links
		write_length(REG_FIRST_LEN, 20'd0);
		write_length(REG_SECOND_LEN, 20'd0);
		write_length(REG_THIRD_LEN, 20'd0);
		run_random(60, 1'b0);
		drain();

		// random lengths; the sink holds off long enough to back up the pipe
		write_length(REG_FIRST_LEN, 20'($urandom_range(0, 20'hFFFFF)));
		write_length(REG_SECOND_LEN, 20'($urandom_range(0, 20'hFFFFF)));
		write_length(REG_THIRD_LEN, 20'($urandom_range(0, 20'hFFFFF)));
		sink_hold = 300;
		run_random(150, 1'b1);
		drain();

		// mixed extremes
		write_length(REG_FIRST_LEN, 20'd1);
		write_length(REG_SECOND_LEN, LEN_MAX);
		write_length(REG_THIRD_LEN, 20'($urandom_range(0, 20'h3FFFF)));
		run_random(150, 1'b0);
		drain();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
